@@ hdl/tcce_pkg.sv @@
// Package for the text console cursor engine: field widths, command codes, result type.
`timescale 1ns / 1ps

package tcce_pkg;

  localparam int unsigned RowW   = 5;
  localparam int unsigned ColW   = 7;
  localparam int unsigned CharW  = 8;
  localparam int unsigned DColW  = 8;
  localparam int unsigned DRowW  = 6;

  localparam logic [CharW-1:0] NewlineCode = 8'd10;
  localparam logic [CharW-1:0] BlankCode   = 8'd32;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_BKSP  = 2'd1,
    OP_MOVE  = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef struct packed {
    logic             cell_write;
    logic [RowW-1:0]  cell_row;
    logic [ColW-1:0]  cell_col;
    logic [CharW-1:0] cell_char;
    logic             scroll_up;
    logic             clear_screen;
    logic [RowW-1:0]  cursor_row;
    logic [ColW-1:0]  cursor_col;
  } result_t;

endpackage

@@ hdl/text_console_cursor_engine.sv @@
// Text console cursor engine: cursor tracking, cell write, scroll and clear requests.
//
//   channel  dir  handshake                fields
//   -------  ---  -----------------------  ------------------------------------------
//   in       in   in_valid_i / in_stall_o  op, char_code, delta_col, delta_row
//   out      out  out_valid_o / out_stall_i cell_write/row/col/char, scroll_up,
//                                          clear_screen, cursor_row, cursor_col
//
// One command per cycle while in_stall_o is low. A command is decoded against
// the cursor registers on transfer; the result is registered in out_q or skid_q.
// Reset clears the cursor to the origin and empties the output and skid registers.
// A stall on the output parks one more result in the skid register; in_stall_o
// rises only while that skid register is full, so it is a pure register output.
`timescale 1ns / 1ps

module text_console_cursor_engine
  import tcce_pkg::*;
#(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,

  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [1:0]              op_i,
  input  logic [CharW-1:0]        char_code_i,
  input  logic signed [DColW-1:0] delta_col_i,
  input  logic signed [DRowW-1:0] delta_row_i,

  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic                    cell_write_o,
  output logic [RowW-1:0]         cell_row_o,
  output logic [ColW-1:0]         cell_col_o,
  output logic [CharW-1:0]        cell_char_o,
  output logic                    scroll_up_o,
  output logic                    clear_screen_o,
  output logic [RowW-1:0]         cursor_row_o,
  output logic [ColW-1:0]         cursor_col_o
);

  localparam logic [ColW-1:0] ColMax = ColW'(COLUMNS - 1);
  localparam logic [RowW-1:0] RowMax = RowW'(ROWS - 1);

  // cursor state
  logic [RowW-1:0] row_q, row_d;
  logic [ColW-1:0] col_q, col_d;

  // output register and skid register
  logic    out_vld_q, out_vld_d;
  logic    skid_vld_q, skid_vld_d;
  result_t out_q, out_d;
  result_t skid_q, skid_d;

  result_t res;
  logic    in_xfer, out_xfer;

  assign in_stall_o = skid_vld_q;
  assign in_xfer    = in_valid_i & ~skid_vld_q;
  assign out_xfer   = out_vld_q & ~out_stall_i;

  // command decode
  always_comb begin
    logic [ColW:0]          col_inc;
    logic [RowW:0]          row_inc;
    logic signed [ColW+1:0] col_sum;
    logic signed [RowW+1:0] row_sum;

    col_inc = {1'b0, col_q} + 1'b1;
    row_inc = {1'b0, row_q} + 1'b1;
    col_sum = $signed({2'b00, col_q}) + (ColW+2)'(delta_col_i);
    row_sum = $signed({2'b00, row_q}) + (RowW+2)'(delta_row_i);

    res   = '0;
    row_d = row_q;
    col_d = col_q;

    case (op_e'(op_i))
      OP_PUT: begin
        if (char_code_i == NewlineCode) begin
          col_d = '0;
          if (row_inc > {1'b0, RowMax}) begin
            res.scroll_up = 1'b1;
            row_d         = RowMax;
          end else begin
            row_d = row_inc[RowW-1:0];
          end
        end else begin
          res.cell_write = 1'b1;
          res.cell_row   = row_q;
          res.cell_col   = col_q;
          res.cell_char  = char_code_i;
          if (col_inc > {1'b0, ColMax}) begin
            // wrap to the next line
            col_d = '0;
            if (row_inc > {1'b0, RowMax}) begin
              res.scroll_up = 1'b1;
              row_d         = RowMax;
            end else begin
              row_d = row_inc[RowW-1:0];
            end
          end else begin
            col_d = col_inc[ColW-1:0];
          end
        end
      end
      OP_BKSP: begin
        if (col_q != '0) begin
          col_d          = col_q - 1'b1;
          res.cell_write = 1'b1;
          res.cell_row   = row_q;
          res.cell_col   = col_q - 1'b1;
          res.cell_char  = BlankCode;
        end else if (row_q != '0) begin
          // back onto the end of the previous line
          row_d          = row_q - 1'b1;
          col_d          = ColMax;
          res.cell_write = 1'b1;
          res.cell_row   = row_q - 1'b1;
          res.cell_col   = ColMax;
          res.cell_char  = BlankCode;
        end
      end
      OP_MOVE: begin
        if (col_sum < 0) begin
          col_d = '0;
        end else if (col_sum > $signed({2'b00, ColMax})) begin
          col_d = ColMax;
        end else begin
          col_d = col_sum[ColW-1:0];
        end
        if (row_sum < 0) begin
          row_d = '0;
        end else if (row_sum > $signed({2'b00, RowMax})) begin
          row_d = RowMax;
        end else begin
          row_d = row_sum[RowW-1:0];
        end
      end
      default: begin
        res.clear_screen = 1'b1;
        row_d            = '0;
        col_d            = '0;
      end
    endcase

    res.cursor_row = row_d;
    res.cursor_col = col_d;
  end

  // output and skid steering
  always_comb begin
    out_vld_d  = out_vld_q;
    skid_vld_d = skid_vld_q;
    out_d      = out_q;
    skid_d     = skid_q;

    if (out_xfer || !out_vld_q) begin
      if (skid_vld_q) begin
        out_d      = skid_q;
        out_vld_d  = 1'b1;
        skid_vld_d = 1'b0;
      end else if (in_xfer) begin
        out_d     = res;
        out_vld_d = 1'b1;
      end else begin
        out_vld_d = 1'b0;
      end
    end else if (in_xfer) begin
      skid_d     = res;
      skid_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q      <= '0;
      col_q      <= '0;
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        row_q <= row_d;
        col_q <= col_d;
      end
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o    = out_vld_q;
  assign cell_write_o   = out_q.cell_write;
  assign cell_row_o     = out_q.cell_row;
  assign cell_col_o     = out_q.cell_col;
  assign cell_char_o    = out_q.cell_char;
  assign scroll_up_o    = out_q.scroll_up;
  assign clear_screen_o = out_q.clear_screen;
  assign cursor_row_o   = out_q.cursor_row;
  assign cursor_col_o   = out_q.cursor_col;

endmodule

@@ bench/text_console_cursor_engine_tb.sv @@
// Self-checking bench for the text console cursor engine: queued commands, predicted results.
`timescale 1ns / 1ps

module text_console_cursor_engine_tb;
  import tcce_pkg::*;

  localparam int unsigned COLUMNS    = 80;
  localparam int unsigned ROWS       = 25;
  localparam int unsigned RandomCmds = 1630;
  localparam int unsigned DrainWait  = 10;  // settle time after the last result is checked

  // One console command as it crosses the input channel.
  typedef struct {
    op_e                     op;
    logic [CharW-1:0]        ch;
    logic signed [DColW-1:0] dcol;
    logic signed [DRowW-1:0] drow;
  } console_cmd_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // Driven side of both channels; known from time zero.
  logic                    in_valid  = 1'b0;
  logic [1:0]              op_drv    = OP_PUT;
  logic [CharW-1:0]        char_drv  = '0;
  logic signed [DColW-1:0] dcol_drv  = '0;
  logic signed [DRowW-1:0] drow_drv  = '0;
  logic                    out_stall = 1'b0;

  logic             in_stall_o;
  logic             out_valid_o;
  logic             cell_write_o;
  logic [RowW-1:0]  cell_row_o;
  logic [ColW-1:0]  cell_col_o;
  logic [CharW-1:0] cell_char_o;
  logic             scroll_up_o;
  logic             clear_screen_o;
  logic [RowW-1:0]  cursor_row_o;
  logic [ColW-1:0]  cursor_col_o;

  console_cmd_t pending_cmds[$];
  result_t      expected_results[$];
  console_cmd_t cur_cmd;

  // Predicted cursor, kept as plain integers so overflow past the edges is visible.
  int cursor_r = 0;
  int cursor_c = 0;

  int unsigned total_cmds  = 0;
  int unsigned sent_count  = 0;
  int unsigned mismatches  = 0;
  int unsigned seen_results = 0;
  int unsigned seen_writes  = 0;
  int unsigned seen_blanks  = 0;
  int unsigned seen_scrolls = 0;
  int unsigned seen_clears  = 0;

  text_console_cursor_engine #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall_o),
    .op_i           (op_drv),
    .char_code_i    (char_drv),
    .delta_col_i    (dcol_drv),
    .delta_row_i    (drow_drv),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall),
    .cell_write_o   (cell_write_o),
    .cell_row_o     (cell_row_o),
    .cell_col_o     (cell_col_o),
    .cell_char_o    (cell_char_o),
    .scroll_up_o    (scroll_up_o),
    .clear_screen_o (clear_screen_o),
    .cursor_row_o   (cursor_row_o),
    .cursor_col_o   (cursor_col_o)
  );

  always #5 clk_i = ~clk_i;

  // Idle rates by thirds of the run: receiver-heavy, sender-heavy, then none.
  function automatic int unsigned sender_idle_pct();
    int unsigned third;
    third = (total_cmds == 0) ? 0 : (sent_count * 3) / total_cmds;
    return (third == 0) ? 33 : (third == 1) ? 49 : 0;
  endfunction

  function automatic int unsigned receiver_idle_pct();
    int unsigned third;
    third = (total_cmds == 0) ? 0 : (sent_count * 3) / total_cmds;
    return (third == 0) ? 49 : (third == 1) ? 33 : 0;
  endfunction

  function automatic int clamp_to(input int v, input int hi);
    return (v < 0) ? 0 : (v > hi) ? hi : v;
  endfunction

  // Applies one command to the predicted cursor and returns the result it should produce.
  task automatic apply_command(input console_cmd_t c, output result_t r);
    int dc;
    int dr;
    r = '0;
    case (c.op)
      OP_PUT: begin
        if (c.ch == NewlineCode) begin
          // newline: cursor only, no cell
          cursor_c = 0;
          cursor_r++;
        end else begin
          r.cell_write = 1'b1;
          r.cell_row   = RowW'(cursor_r);
          r.cell_col   = ColW'(cursor_c);
          r.cell_char  = c.ch;
          cursor_c++;
          if (cursor_c >= COLUMNS) begin
            cursor_c = 0;
            cursor_r++;
          end
        end
        // falling off the bottom: scroll and stay on the last row
        if (cursor_r >= ROWS) begin
          r.scroll_up = 1'b1;
          cursor_r    = ROWS - 1;
        end
      end
      OP_BKSP: begin
        // at the origin backspace is a no-op
        if (cursor_c != 0 || cursor_r != 0) begin
          if (cursor_c == 0) begin
            cursor_r--;
            cursor_c = COLUMNS - 1;
          end else begin
            cursor_c--;
          end
          r.cell_write = 1'b1;
          r.cell_row   = RowW'(cursor_r);
          r.cell_col   = ColW'(cursor_c);
          r.cell_char  = BlankCode;
        end
      end
      OP_MOVE: begin
        dc       = int'(c.dcol);
        dr       = int'(c.drow);
        cursor_c = clamp_to(cursor_c + dc, COLUMNS - 1);
        cursor_r = clamp_to(cursor_r + dr, ROWS - 1);
      end
      default: begin
        r.clear_screen = 1'b1;
        cursor_r       = 0;
        cursor_c       = 0;
      end
    endcase
    r.cursor_row = RowW'(cursor_r);
    r.cursor_col = ColW'(cursor_c);
  endtask

  task automatic compare_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  function automatic console_cmd_t make_cmd(input op_e op, input int ch, input int dc, input int dr);
    console_cmd_t c;
    c.op   = op;
    c.ch   = CharW'(ch);
    c.dcol = DColW'(dc);
    c.drow = DRowW'(dr);
    return c;
  endfunction

  // Random command; unused fields always carry junk.
  function automatic console_cmd_t random_cmd(input bit text_only);
    console_cmd_t c;
    int unsigned  pick;
    c.ch   = CharW'($urandom_range(255));
    c.dcol = DColW'($urandom);
    c.drow = DRowW'($urandom);
    pick   = text_only ? 0 : $urandom_range(99);
    if (pick < 50) begin
      c.op = OP_PUT;
      if ($urandom_range(9) == 0) c.ch = NewlineCode;
    end else if (pick < 72) begin
      c.op = OP_BKSP;
    end else if (pick < 96) begin
      c.op = OP_MOVE;
      // half of the moves are short hops, so the cursor is not pinned to the edges
      if ($urandom_range(1)) begin
        c.dcol = DColW'(int'($urandom_range(10)) - 5);
        c.drow = DRowW'(int'($urandom_range(6)) - 3);
      end
    end else begin
      c.op = OP_CLEAR;
    end
    return c;
  endfunction

  // Driver: holds a command until its transfer, then predicts and loads the next.
  always @(posedge clk_i) begin : cmd_driver
    result_t r;
    if (rst_ni) begin
      if (in_valid && !in_stall_o) begin
        apply_command(cur_cmd, r);
        expected_results.push_back(r);
        sent_count++;
      end
      if (!in_valid || !in_stall_o) begin
        if (pending_cmds.size() != 0 && $urandom_range(99) >= sender_idle_pct()) begin
          cur_cmd  = pending_cmds.pop_front();
          op_drv   <= cur_cmd.op;
          char_drv <= cur_cmd.ch;
          dcol_drv <= cur_cmd.dcol;
          drow_drv <= cur_cmd.drow;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transfer against the oldest prediction.
  always @(posedge clk_i) begin : result_monitor
    result_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with nothing expected");
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          compare_field("cell_write", want.cell_write, cell_write_o);
          compare_field("cell_row", want.cell_row, cell_row_o);
          compare_field("cell_col", want.cell_col, cell_col_o);
          compare_field("cell_char", want.cell_char, cell_char_o);
          compare_field("scroll_up", want.scroll_up, scroll_up_o);
          compare_field("clear_screen", want.clear_screen, clear_screen_o);
          compare_field("cursor_row", want.cursor_row, cursor_row_o);
          compare_field("cursor_col", want.cursor_col, cursor_col_o);
          seen_results++;
          if (want.cell_write && want.cell_char == BlankCode) seen_blanks++;
          if (want.cell_write) seen_writes++;
          if (want.scroll_up) seen_scrolls++;
          if (want.clear_screen) seen_clears++;
        end
      end
      out_stall <= ($urandom_range(99) < receiver_idle_pct());
    end
  end

  initial begin : stimulus
    int unsigned n;
    int unsigned burst;
    // Directed: edges, wraps, scrolls, clamps, backspace corner cases.
    pending_cmds.push_back(make_cmd(OP_CLEAR, 255, -1, -1));   // clear with junk fields
    pending_cmds.push_back(make_cmd(OP_BKSP, 255, 127, 31));   // backspace at origin
    pending_cmds.push_back(make_cmd(OP_PUT, 0, 0, 0));
    pending_cmds.push_back(make_cmd(OP_PUT, 255, -128, -32));
    pending_cmds.push_back(make_cmd(OP_PUT, NewlineCode, 0, 0));
    pending_cmds.push_back(make_cmd(OP_BKSP, 0, 0, 0));        // crosses back to prior line
    pending_cmds.push_back(make_cmd(OP_MOVE, 0, 127, 31));     // clamp to bottom-right
    pending_cmds.push_back(make_cmd(OP_PUT, 8'h5A, 0, 0));     // last cell: wrap + scroll
    pending_cmds.push_back(make_cmd(OP_PUT, NewlineCode, 0, 0)); // newline on last row
    pending_cmds.push_back(make_cmd(OP_MOVE, 255, -128, -32)); // clamp to origin
    pending_cmds.push_back(make_cmd(OP_MOVE, NewlineCode, 1, 0)); // char ignored by move
    pending_cmds.push_back(make_cmd(OP_MOVE, 0, 0, -1));
    pending_cmds.push_back(make_cmd(OP_MOVE, 0, 78, 0));
    pending_cmds.push_back(make_cmd(OP_PUT, 8'h71, 0, 0));     // wrap, no scroll
    pending_cmds.push_back(make_cmd(OP_BKSP, 0, 0, 0));
    pending_cmds.push_back(make_cmd(OP_BKSP, 0, 0, 0));
    pending_cmds.push_back(make_cmd(OP_MOVE, 0, -1, 23));
    pending_cmds.push_back(make_cmd(OP_PUT, NewlineCode, 0, 0)); // onto last row, no scroll
    pending_cmds.push_back(make_cmd(OP_MOVE, 0, 0, 0));
    pending_cmds.push_back(make_cmd(OP_CLEAR, 0, 0, 0));

    // Random: single commands mixed with runs of text that wrap and scroll.
    n = 0;
    while (n < RandomCmds) begin
      if ($urandom_range(4) == 0) begin
        burst = $urandom_range(90, 5);
        repeat (burst) pending_cmds.push_back(random_cmd(1'b1));
        n += burst;
      end else begin
        pending_cmds.push_back(random_cmd(1'b0));
        n++;
      end
    end
    total_cmds = pending_cmds.size();

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // every command transferred and every prediction checked
    while (sent_count != total_cmds || expected_results.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    $display("checked %0d results from %0d commands", seen_results, total_cmds);
    $display("cell writes %0d (blanks %0d), scrolls %0d, clears %0d",
             seen_writes, seen_blanks, seen_scrolls, seen_clears);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("timeout: %0d of %0d commands sent, %0d results pending",
             sent_count, total_cmds, expected_results.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule

@@ text_console_cursor_engine.f @@
hdl/tcce_pkg.sv
hdl/text_console_cursor_engine.sv
bench/text_console_cursor_engine_tb.sv
